FILE: hdl/rtgp_pkg.sv
// Shared types and constants for the radar target gate with hit/drop persistence.
// Used by rtgp_gate and radar_target_gate_persistence; depends on nothing.
package rtgp_pkg;

  // Record word layout: bit 15 is the sign (set = positive), low bits are the magnitude.
  localparam int WORD_W = 16;
  localparam int MAG_W  = 15;

  // Configuration register widths
  localparam int MIN_RANGE_W = 13;
  localparam int TAN_W       = 16;
  localparam int SPEED_GATE_W = 15;
  localparam int CNT_W       = 8;

  // Farthest forward distance accepted
  localparam logic [MAG_W-1:0] Y_LIMIT = 15'd8000;

  // Fraction bits of the tangent limit; |x| is scaled by the same amount
  localparam int TAN_FRAC_W = 8;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_RANGE     = 3'd0,
    CFG_TAN_MAX_Q8    = 3'd1,
    CFG_SPEED_GATE    = 3'd2,
    CFG_HITS_NEEDED   = 3'd3,
    CFG_DROPS_ALLOWED = 3'd4
  } cfg_idx_t;

  // Gate thresholds handed to the gating logic
  typedef struct packed {
    logic [MIN_RANGE_W-1:0]  min_range;
    logic [TAN_W-1:0]        tan_max_q8;
    logic [SPEED_GATE_W-1:0] speed_gate;
  } gate_cfg_t;

  // Decoded record plus the gating verdict
  typedef struct packed {
    logic signed [WORD_W-1:0] pos_x;
    logic signed [WORD_W-1:0] pos_y;
    logic signed [WORD_W-1:0] speed;
    logic                     seen;
  } gate_res_t;

endpackage

FILE: hdl/rtgp_gate.sv
// Decodes one target record and applies the range, angle and speed gates.
// Purely combinational; uses rtgp_pkg types and constants.
module rtgp_gate (
  input  logic [rtgp_pkg::WORD_W-1:0] raw_x,
  input  logic [rtgp_pkg::WORD_W-1:0] raw_y,
  input  logic [rtgp_pkg::WORD_W-1:0] raw_speed,
  input  rtgp_pkg::gate_cfg_t         cfg,
  output rtgp_pkg::gate_res_t         res
);

  localparam int LHS_W  = rtgp_pkg::MAG_W + rtgp_pkg::TAN_FRAC_W;
  localparam int PROD_W = rtgp_pkg::MAG_W + rtgp_pkg::TAN_W;

  logic [rtgp_pkg::MAG_W-1:0]  mag_x, mag_y, mag_s;
  logic [rtgp_pkg::WORD_W-1:0] ext_x, ext_y, ext_s;
  logic [LHS_W-1:0]            x_scaled;
  logic [PROD_W-1:0]           y_tan;
  logic                        any_word, y_ok, range_ok, angle_ok, speed_ok;

  assign mag_x = raw_x[rtgp_pkg::MAG_W-1:0];
  assign mag_y = raw_y[rtgp_pkg::MAG_W-1:0];
  assign mag_s = raw_speed[rtgp_pkg::MAG_W-1:0];

  assign ext_x = {1'b0, mag_x};
  assign ext_y = {1'b0, mag_y};
  assign ext_s = {1'b0, mag_s};

  // Sign-magnitude decode; lateral axis is mirrored
  always_comb begin
    res.pos_x = raw_x[rtgp_pkg::MAG_W] ? -ext_x : ext_x;
    res.pos_y = raw_y[rtgp_pkg::MAG_W] ? ext_y : -ext_y;
    res.speed = raw_speed[rtgp_pkg::MAG_W] ? ext_s : -ext_s;
  end

  // Range gate: strictly positive, at or above min_range, not beyond the limit
  assign any_word = |{raw_x, raw_y, raw_speed};
  assign y_ok     = raw_y[rtgp_pkg::MAG_W] && (mag_y != '0);
  assign range_ok = (mag_y >= rtgp_pkg::MAG_W'(cfg.min_range)) && (mag_y <= rtgp_pkg::Y_LIMIT);

  // Angle gate: |x| * 256 <= y * tan_max_q8
  assign x_scaled = {mag_x, {rtgp_pkg::TAN_FRAC_W{1'b0}}};
  assign y_tan    = PROD_W'(mag_y) * PROD_W'(cfg.tan_max_q8);
  assign angle_ok = PROD_W'(x_scaled) <= y_tan;

  // Speed gate, zero disables it
  assign speed_ok = (cfg.speed_gate == '0) || (mag_s <= cfg.speed_gate);

  assign res.seen = any_word && y_ok && range_ok && angle_ok && speed_ok;

endmodule

FILE: hdl/radar_target_gate_persistence.sv
// Top level: input register, gating, per-slot hit/drop persistence, result register.
// Depends on rtgp_pkg and rtgp_gate.
//
// Usage:
//   Input channel (in_valid/in_ready) takes one target record per transaction: slot,
//   three sign-magnitude words and a distance word. Result channel (out_valid/out_ready)
//   returns one result per record, in order: slot, present flag, decoded x/y/speed and
//   the distance word unchanged.
//   Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the gate
//   thresholds and persistence limits; it is always ready. Write it only while idle.
//   Each record passes the input register, then the result register. Throughput: one
//   record per cycle while the result channel is not stalled; the persistence counters
//   of a slot are updated in the same cycle the result register loads, so back-to-back
//   records of the same slot see each other's updates.
//   Stall: while a result waits and out_ready is low the result register holds; the input
//   register fills and then in_ready drops until the result is taken.
//   Reset (rst_n low, synchronous): both stages empty, all counters zero, registers
//   return to min_range 0, tan_max_q8 256, speed_gate 0, hits_needed 1,
//   drops_allowed 1.
module radar_target_gate_persistence #(
  parameter int SLOT_COUNT = 3
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_slot,
  input  logic [rtgp_pkg::WORD_W-1:0]       in_raw_x,
  input  logic [rtgp_pkg::WORD_W-1:0]       in_raw_y,
  input  logic [rtgp_pkg::WORD_W-1:0]       in_raw_speed,
  input  logic [rtgp_pkg::WORD_W-1:0]       in_pixel_distance,

  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [1:0]                        out_slot_out,
  output logic                              out_present,
  output logic signed [rtgp_pkg::WORD_W-1:0] out_pos_x,
  output logic signed [rtgp_pkg::WORD_W-1:0] out_pos_y,
  output logic signed [rtgp_pkg::WORD_W-1:0] out_speed,
  output logic [rtgp_pkg::WORD_W-1:0]       out_distance_out,

  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rtgp_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [rtgp_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int CW = rtgp_pkg::CNT_W;

  // Configuration registers
  logic [rtgp_pkg::MIN_RANGE_W-1:0]  min_range_r;
  logic [rtgp_pkg::TAN_W-1:0]        tan_max_q8_r;
  logic [rtgp_pkg::SPEED_GATE_W-1:0] speed_gate_r;
  logic [CW-1:0]                     hits_needed_r;
  logic [CW-1:0]                     drops_allowed_r;

  // Input stage
  logic                        s1_valid_r;
  logic [1:0]                  s1_slot_r;
  logic [rtgp_pkg::WORD_W-1:0] s1_raw_x_r, s1_raw_y_r, s1_raw_speed_r, s1_dist_r;

  // Result stage
  logic                              out_valid_r;
  logic [1:0]                        out_slot_r;
  logic                              out_present_r, present_nxt;
  logic signed [rtgp_pkg::WORD_W-1:0] out_pos_x_r, out_pos_y_r, out_speed_r;
  logic [rtgp_pkg::WORD_W-1:0]       out_dist_r;

  // Persistence counters, one pair per slot
  logic [CW-1:0] hit_cnt_r  [SLOT_COUNT];
  logic [CW-1:0] drop_cnt_r [SLOT_COUNT];
  logic [CW-1:0] hit_cnt_nxt  [SLOT_COUNT];
  logic [CW-1:0] drop_cnt_nxt [SLOT_COUNT];

  logic                 s2_free, s2_load;
  logic                 slot_ok;
  logic [CW-1:0]        sel_hit, sel_drop, hit_inc, drop_inc;
  rtgp_pkg::gate_cfg_t  gate_cfg;
  rtgp_pkg::gate_res_t  gate_res;

  // Handshake
  assign s2_free   = !out_valid_r || out_ready;
  assign s2_load   = s1_valid_r && s2_free;
  assign in_ready  = !s1_valid_r || s2_free;
  assign cfg_ready = 1'b1;

  // Gating on the registered record
  assign gate_cfg.min_range  = min_range_r;
  assign gate_cfg.tan_max_q8 = tan_max_q8_r;
  assign gate_cfg.speed_gate = speed_gate_r;

  rtgp_gate u_gate (
    .raw_x     (s1_raw_x_r),
    .raw_y     (s1_raw_y_r),
    .raw_speed (s1_raw_speed_r),
    .cfg       (gate_cfg),
    .res       (gate_res)
  );

  // Persistence: pick the slot's counters, then update them
  always_comb begin
    sel_hit  = '0;
    sel_drop = '0;
    slot_ok  = 1'b0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (int'(s1_slot_r) == i) begin
        sel_hit  = hit_cnt_r[i];
        sel_drop = drop_cnt_r[i];
        slot_ok  = 1'b1;
      end
    end

    hit_inc  = (sel_hit < hits_needed_r) ? sel_hit + CW'(1) : sel_hit;
    drop_inc = (sel_drop < drops_allowed_r) ? sel_drop + CW'(1) : sel_drop;

    if (!slot_ok) begin
      present_nxt = 1'b0;
    end else if (gate_res.seen) begin
      present_nxt = !(hit_inc < hits_needed_r);
    end else begin
      present_nxt = drop_inc < drops_allowed_r;
    end

    for (int i = 0; i < SLOT_COUNT; i++) begin
      hit_cnt_nxt[i]  = hit_cnt_r[i];
      drop_cnt_nxt[i] = drop_cnt_r[i];
      if (s2_load && int'(s1_slot_r) == i) begin
        if (gate_res.seen) begin
          hit_cnt_nxt[i]  = hit_inc;
          drop_cnt_nxt[i] = '0;
        end else begin
          hit_cnt_nxt[i]  = '0;
          drop_cnt_nxt[i] = drop_inc;
        end
      end
    end
  end

  // Control state, configuration and counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      min_range_r     <= '0;
      tan_max_q8_r    <= rtgp_pkg::TAN_W'(256);
      speed_gate_r    <= '0;
      hits_needed_r   <= CW'(1);
      drops_allowed_r <= CW'(1);
      for (int i = 0; i < SLOT_COUNT; i++) begin
        hit_cnt_r[i]  <= '0;
        drop_cnt_r[i] <= '0;
      end
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s2_free) begin
        out_valid_r <= s1_valid_r;
      end
      for (int i = 0; i < SLOT_COUNT; i++) begin
        hit_cnt_r[i]  <= hit_cnt_nxt[i];
        drop_cnt_r[i] <= drop_cnt_nxt[i];
      end
      if (cfg_valid) begin
        case (rtgp_pkg::cfg_idx_t'(cfg_index))
          rtgp_pkg::CFG_MIN_RANGE:     min_range_r     <= cfg_data[rtgp_pkg::MIN_RANGE_W-1:0];
          rtgp_pkg::CFG_TAN_MAX_Q8:    tan_max_q8_r    <= cfg_data[rtgp_pkg::TAN_W-1:0];
          rtgp_pkg::CFG_SPEED_GATE:    speed_gate_r    <= cfg_data[rtgp_pkg::SPEED_GATE_W-1:0];
          rtgp_pkg::CFG_HITS_NEEDED:   hits_needed_r   <= cfg_data[CW-1:0];
          rtgp_pkg::CFG_DROPS_ALLOWED: drops_allowed_r <= cfg_data[CW-1:0];
          default: ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_slot_r      <= in_slot;
      s1_raw_x_r     <= in_raw_x;
      s1_raw_y_r     <= in_raw_y;
      s1_raw_speed_r <= in_raw_speed;
      s1_dist_r      <= in_pixel_distance;
    end
    if (s2_load) begin
      out_slot_r    <= s1_slot_r;
      out_present_r <= present_nxt;
      out_pos_x_r   <= gate_res.pos_x;
      out_pos_y_r   <= gate_res.pos_y;
      out_speed_r   <= gate_res.speed;
      out_dist_r    <= s1_dist_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_slot_out     = out_slot_r;
  assign out_present      = out_present_r;
  assign out_pos_x        = out_pos_x_r;
  assign out_pos_y        = out_pos_y_r;
  assign out_speed        = out_speed_r;
  assign out_distance_out = out_dist_r;

  // A slot never holds a pending hit streak and a miss streak at once
  for (genvar g = 0; g < SLOT_COUNT; g++) begin : g_cnt_chk
    a_streak_excl: assert property (@(posedge clk) disable iff (!rst_n)
      hit_cnt_r[g] != '0 |-> drop_cnt_r[g] == '0)
      else $error("slot %0d has both hit and drop streaks", g);
  end

  // Records for slots that do not exist are never reported present
  a_bad_slot_absent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && int'(out_slot_out) >= SLOT_COUNT |-> !out_present)
    else $error("present set for out-of-range slot");

  // Backpressure at the input only when the input register is occupied
  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> s1_valid_r && out_valid_r && !out_ready)
    else $error("input stalled without a full pipeline");

endmodule
